// ----- rtl/dtq_pkg.sv -----
// Package for the deadline timer queue: sizes, command and result codes,
// and the compare-unit result type. No dependencies.
package dtq_pkg;

    localparam int NUM_TIMERS = 32;
    localparam int IDXW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    localparam logic [19:0] NS_PER_MS = 20'd1000000;
    localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

    localparam logic [1:0] MODE_ARM    = 2'd0;
    localparam logic [1:0] MODE_CANCEL = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_FIRED  = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;

    typedef struct packed {
        logic [63:0] key;     // biased distance, smaller is earlier
        logic [31:0] rec;     // age in arm counts, smaller is newer
        logic        due;
        logic        better;
    } cmp_res_t;

endpackage

// ----- rtl/deadline_timer_queue_unit.sv -----
// Deadline timer queue, top level. Holds the timer table and the sequencer
// that drives the shared compare unit and the period multiplier. Depends on dtq_pkg, dtq_cmp.
//
// Usage:
//   Input channel s_*: one beat is a command. mode 0 arms timer_id with
//   period_ms and one_shot, mode 1 cancels it, mode 2 is a tick at now_ns,
//   mode 3 does nothing and gives no result.
//   Result channel m_*: arm/cancel give one status beat. A tick gives one
//   kind-1 beat per expired timer (earliest deadline first, newest first on
//   ties), then one kind-2 report with the wait to the next deadline. The
//   final beat of a command carries m_last.
//   Timing: s_ready is high only while the sequencer is idle. Arm passes
//   through multiply, write and emit to its status beat, cancel straight
//   to emit. A tick with F expirations runs F selection scans, one scan
//   that finds nothing due and one report scan before its report, each a
//   full pass over the table, one entry a cycle through the single compare
//   unit; each expiry adds fire and emit, and a periodic re-arm adds the
//   multiplier and the write steps.
//   Results sit in one output register; while the receiver stalls the
//   sequencer holds in its emit state, no state is lost.
//   Reset (aresetn low, synchronous) disarms all timers, clears the arm
//   counter and drops m_valid. Table payload is not cleared.
module deadline_timer_queue_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [4:0]  s_timer_id,
    input  logic [31:0] s_period_ms,
    input  logic        s_one_shot,
    input  logic [63:0] s_now_ns,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [4:0]  m_fired_id,
    output logic        m_status,
    output logic [63:0] m_wait_ns,
    output logic        m_queue_empty,
    output logic        m_last
);
    import dtq_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ARM_MUL, ST_ARM_WR, ST_STAT, ST_SCAN,
        ST_FIRE, ST_FIRE_MUL, ST_FIRE_WR, ST_EMIT_FIRE, ST_RPT
    } state_t;

    // timer table
    logic [63:0] deadline_reg [NUM_TIMERS];
    logic [31:0] period_reg   [NUM_TIMERS];
    logic [31:0] order_reg    [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] single_reg;
    logic [NUM_TIMERS-1:0] armed_reg;
    logic [NUM_TIMERS-1:0] done_reg;
    logic [31:0] counter_reg;

    state_t      state_reg;
    logic [IDXW-1:0] idx_reg;     // scan pointer
    logic [IDXW-1:0] cur_reg;     // entry being armed or fired
    logic [4:0]  id_reg;
    logic        st_reg;
    logic [63:0] now_reg;
    logic [51:0] prod_reg;
    logic        due_phase_reg;   // 1: looking for due timers, 0: report scan
    logic        have_reg;
    logic [63:0] best_key_reg;
    logic [31:0] best_rec_reg;
    logic [IDXW-1:0] best_idx_reg;

    logic        m_valid_reg;
    logic [1:0]  m_kind_reg;
    logic [4:0]  m_fired_id_reg;
    logic        m_status_reg;
    logic [63:0] m_wait_reg;
    logic        m_empty_reg;
    logic        m_last_reg;

    cmp_res_t        cres;
    logic [IDXW-1:0] s_idx;
    logic            id_ok;
    logic            cand;
    logic            out_free;
    logic            emit;
    logic [51:0]     prod_w;
    logic [63:0]     best_dist;

    assign s_idx     = IDXW'(s_timer_id);
    assign id_ok     = ({1'b0, s_timer_id} < 6'(NUM_TIMERS));
    assign out_free  = !m_valid_reg || m_ready;
    // a new beat loads the output register this cycle
    assign emit      = out_free && (state_reg inside {ST_STAT, ST_EMIT_FIRE, ST_RPT});
    assign prod_w    = period_reg[cur_reg] * NS_PER_MS;
    assign best_dist = best_key_reg ^ SIGN64;

    dtq_cmp u_cmp (
        .deadline  (deadline_reg[idx_reg]),
        .now       (now_reg),
        .order     (order_reg[idx_reg]),
        .counter   (counter_reg),
        .best_key  (best_key_reg),
        .best_rec  (best_rec_reg),
        .have_best (have_reg),
        .res       (cres)
    );

    // entry takes part in the current scan
    assign cand = armed_reg[idx_reg] &&
                  (!due_phase_reg || (!done_reg[idx_reg] && cres.due));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            armed_reg   <= '0;
            counter_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !emit) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        id_reg  <= s_timer_id;
                        cur_reg <= s_idx;
                        now_reg <= s_now_ns;
                        case (s_mode)
                            MODE_ARM: begin
                                if (id_ok && !armed_reg[s_idx]) begin
                                    period_reg[s_idx] <= s_period_ms;
                                    single_reg[s_idx] <= s_one_shot;
                                    st_reg            <= 1'b0;
                                    state_reg         <= ST_ARM_MUL;
                                end else begin
                                    st_reg    <= 1'b1;
                                    state_reg <= ST_STAT;
                                end
                            end
                            MODE_CANCEL: begin
                                if (id_ok && armed_reg[s_idx]) begin
                                    armed_reg[s_idx] <= 1'b0;
                                    st_reg           <= 1'b0;
                                end else begin
                                    st_reg <= 1'b1;
                                end
                                state_reg <= ST_STAT;
                            end
                            MODE_TICK: begin
                                done_reg      <= '0;
                                idx_reg       <= '0;
                                have_reg      <= 1'b0;
                                due_phase_reg <= 1'b1;
                                state_reg     <= ST_SCAN;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_ARM_MUL: begin
                    prod_reg  <= prod_w;
                    state_reg <= ST_ARM_WR;
                end
                ST_ARM_WR: begin
                    deadline_reg[cur_reg] <= now_reg + 64'(prod_reg);
                    order_reg[cur_reg]    <= counter_reg;
                    counter_reg           <= counter_reg + 32'd1;
                    armed_reg[cur_reg]    <= 1'b1;
                    state_reg             <= ST_STAT;
                end
                ST_STAT: begin
                    if (out_free) begin
                        m_valid_reg    <= 1'b1;
                        m_kind_reg     <= KIND_STATUS;
                        m_fired_id_reg <= id_reg;
                        m_status_reg   <= st_reg;
                        m_wait_reg     <= '0;
                        m_empty_reg    <= ~|armed_reg;
                        m_last_reg     <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end
                ST_SCAN: begin
                    if (cand && cres.better) begin
                        have_reg     <= 1'b1;
                        best_key_reg <= cres.key;
                        best_rec_reg <= cres.rec;
                        best_idx_reg <= idx_reg;
                    end
                    if (idx_reg == IDXW'(NUM_TIMERS - 1)) begin
                        idx_reg <= '0;
                        if (!due_phase_reg) begin
                            state_reg <= ST_RPT;
                        end else if (have_reg || cand) begin
                            state_reg <= ST_FIRE;
                        end else begin
                            due_phase_reg <= 1'b0;
                        end
                    end else begin
                        idx_reg <= idx_reg + IDXW'(1);
                    end
                end
                ST_FIRE: begin
                    cur_reg <= best_idx_reg;
                    done_reg[best_idx_reg] <= 1'b1;
                    if (single_reg[best_idx_reg]) begin
                        armed_reg[best_idx_reg] <= 1'b0;
                        state_reg <= ST_EMIT_FIRE;
                    end else begin
                        state_reg <= ST_FIRE_MUL;
                    end
                end
                ST_FIRE_MUL: begin
                    prod_reg  <= prod_w;
                    state_reg <= ST_FIRE_WR;
                end
                ST_FIRE_WR: begin
                    deadline_reg[cur_reg] <= now_reg + 64'(prod_reg);
                    order_reg[cur_reg]    <= counter_reg;
                    counter_reg           <= counter_reg + 32'd1;
                    state_reg             <= ST_EMIT_FIRE;
                end
                ST_EMIT_FIRE: begin
                    if (out_free) begin
                        m_valid_reg    <= 1'b1;
                        m_kind_reg     <= KIND_FIRED;
                        m_fired_id_reg <= 5'(best_idx_reg);
                        m_status_reg   <= 1'b0;
                        m_wait_reg     <= '0;
                        m_empty_reg    <= ~|armed_reg;
                        m_last_reg     <= 1'b0;
                        have_reg       <= 1'b0;
                        idx_reg        <= '0;
                        state_reg      <= ST_SCAN;
                    end
                end
                ST_RPT: begin
                    if (out_free) begin
                        m_valid_reg    <= 1'b1;
                        m_kind_reg     <= KIND_REPORT;
                        m_fired_id_reg <= have_reg ? 5'(best_idx_reg) : 5'd0;
                        m_status_reg   <= 1'b0;
                        // still-due or empty: zero wait
                        m_wait_reg     <= (!have_reg || best_dist[63] ||
                                           best_dist == 64'd0) ? 64'd0 : best_dist;
                        m_empty_reg    <= ~|armed_reg;
                        m_last_reg     <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_fired_id    = m_fired_id_reg;
    assign m_status      = m_status_reg;
    assign m_wait_ns     = m_wait_reg;
    assign m_queue_empty = m_empty_reg;
    assign m_last        = m_last_reg;

endmodule

// ----- rtl/dtq_cmp.sv -----
// Shared compare unit: biased deadline key, recency, due flag and the
// "precedes current best" decision. Depends on dtq_pkg.
module dtq_cmp (
    input  logic [63:0]       deadline,
    input  logic [63:0]       now,
    input  logic [31:0]       order,
    input  logic [31:0]       counter,
    input  logic [63:0]       best_key,
    input  logic [31:0]       best_rec,
    input  logic              have_best,
    output dtq_pkg::cmp_res_t res
);
    import dtq_pkg::*;

    always_comb begin
        res.key    = (deadline - now) ^ SIGN64;
        res.rec    = counter - order;
        res.due    = (res.key <= SIGN64);
        res.better = !have_best || (res.key < best_key) ||
                     ((res.key == best_key) && (res.rec < best_rec));
    end

endmodule

// ----- tb/deadline_timer_queue_unit_tb.sv -----
// Self-checking bench for deadline_timer_queue_unit: arm, cancel and tick
// beats checked against a timer-table predictor. Depends on dtq_pkg.
`timescale 1ns / 100ps

module deadline_timer_queue_unit_tb;
    import dtq_pkg::*;

    localparam int LIMIT_CYCLES = 1500000;

    typedef struct {
        logic [1:0]  mode;
        logic [4:0]  timer_id;
        logic [31:0] period_ms;
        logic        one_shot;
        logic [63:0] now_ns;
    } cmd_t;

    typedef struct {
        logic [1:0]  kind;
        logic [4:0]  fired_id;
        logic        status;
        logic [63:0] wait_ns;
        logic        queue_empty;
        logic        last;
    } beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode = '0;
    logic [4:0]  s_timer_id = '0;
    logic [31:0] s_period_ms = '0;
    logic        s_one_shot = 1'b0;
    logic [63:0] s_now_ns = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [4:0]  m_fired_id;
    logic        m_status;
    logic [63:0] m_wait_ns;
    logic        m_queue_empty;
    logic        m_last;

    deadline_timer_queue_unit DUT (.*);

    always #6 aclk = ~aclk;

    // predictor copy of the timer table
    logic        tm_armed [NUM_TIMERS];
    logic [63:0] tm_deadline [NUM_TIMERS];
    logic [31:0] tm_period [NUM_TIMERS];
    logic        tm_single [NUM_TIMERS];
    logic [31:0] tm_order [NUM_TIMERS];
    logic [31:0] arm_count;

    cmd_t  cmd_queue[$];
    beat_t expected_beats[$];
    int    errors = 0;
    int    cycles = 0;
    int    beats_seen = 0;
    int    fired_seen = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    int    hold_off = 0;   // long receiver stall, in cycles
    bit    sender_pause = 0;

    function automatic bit none_armed();
        for (int i = 0; i < NUM_TIMERS; i++)
            if (tm_armed[i]) return 0;
        return 1;
    endfunction

    function automatic bit earlier(int a, int b, logic [63:0] now);
        logic [63:0] ka, kb;
        ka = (tm_deadline[a] - now) ^ SIGN64;
        kb = (tm_deadline[b] - now) ^ SIGN64;
        if (ka != kb) return ka < kb;
        return (arm_count - tm_order[a]) < (arm_count - tm_order[b]);
    endfunction

    function automatic void rearm(int i, logic [63:0] now);
        tm_deadline[i] = now + 64'(tm_period[i]) * 64'(NS_PER_MS);
        tm_order[i] = arm_count;
        arm_count++;
        tm_armed[i] = 1;
    endfunction

    function automatic void push_beat(logic [1:0] k, logic [4:0] id, logic st,
                                      logic [63:0] w, logic lst);
        beat_t b;
        b.kind = k; b.fired_id = id; b.status = st; b.wait_ns = w;
        b.queue_empty = none_armed(); b.last = lst;
        expected_beats.push_back(b);
    endfunction

    // Works out the beats that one accepted command causes.
    function automatic void predict_timer_beats(cmd_t c);
        bit done [NUM_TIMERS];
        int best;
        logic st;
        logic [63:0] d;
        if (c.mode == MODE_ARM || c.mode == MODE_CANCEL) begin
            st = 1;
            if (c.mode == MODE_ARM && !tm_armed[c.timer_id]) begin
                tm_period[c.timer_id] = c.period_ms;
                tm_single[c.timer_id] = c.one_shot;
                rearm(c.timer_id, c.now_ns);
                st = 0;
            end else if (c.mode == MODE_CANCEL && tm_armed[c.timer_id]) begin
                tm_armed[c.timer_id] = 0;
                st = 0;
            end
            push_beat(KIND_STATUS, c.timer_id, st, '0, 1'b1);
        end else if (c.mode == MODE_TICK) begin
            foreach (done[i]) done[i] = 0;
            forever begin
                best = -1;
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (!tm_armed[i] || done[i]) continue;
                    if (((tm_deadline[i] - c.now_ns) ^ SIGN64) > SIGN64) continue;
                    if (best < 0 || earlier(i, best, c.now_ns)) best = i;
                end
                if (best < 0) break;
                done[best] = 1;
                if (tm_single[best]) tm_armed[best] = 0;
                else rearm(best, c.now_ns);
                push_beat(KIND_FIRED, 5'(best), 1'b0, '0, 1'b0);
            end
            best = -1;
            for (int i = 0; i < NUM_TIMERS; i++)
                if (tm_armed[i] && (best < 0 || earlier(i, best, c.now_ns))) best = i;
            if (best < 0) begin
                push_beat(KIND_REPORT, '0, 1'b0, '0, 1'b1);
            end else begin
                d = tm_deadline[best] - c.now_ns;
                push_beat(KIND_REPORT, 5'(best), 1'b0, d[63] ? 64'd0 : d, 1'b1);
            end
        end
    endfunction

    // Driver: takes the next command when the current beat is accepted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready) begin
                if (s_valid) predict_timer_beats('{s_mode, s_timer_id, s_period_ms,
                                                   s_one_shot, s_now_ns});
                if (cmd_queue.size() > 0 && !sender_pause &&
                    $urandom_range(99) >= send_idle_pct) begin
                    cmd_t c;
                    c = cmd_queue.pop_front();
                    s_valid <= 1'b1;
                    s_mode <= c.mode; s_timer_id <= c.timer_id;
                    s_period_ms <= c.period_ms; s_one_shot <= c.one_shot;
                    s_now_ns <= c.now_ns;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted down on its own.
    always @(posedge aclk) begin
        if (hold_off > 0) hold_off <= hold_off - 1;
    end

    // Monitor: compares each accepted result beat with the oldest expectation.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                beat_t e;
                beats_seen++;
                if (m_kind == KIND_FIRED) fired_seen++;
                if (expected_beats.size() == 0) begin
                    $error("unexpected result beat, kind %0d", m_kind);
                    errors++;
                end else begin
                    e = expected_beats.pop_front();
                    if (m_kind !== e.kind) begin
                        $error("kind: expected %0d, got %0d", e.kind, m_kind); errors++;
                    end
                    if (m_fired_id !== e.fired_id) begin
                        $error("fired_id: expected %0d, got %0d", e.fired_id, m_fired_id);
                        errors++;
                    end
                    if (m_status !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, m_status);
                        errors++;
                    end
                    if (m_wait_ns !== e.wait_ns) begin
                        $error("wait_ns: expected %0h, got %0h", e.wait_ns, m_wait_ns);
                        errors++;
                    end
                    if (m_queue_empty !== e.queue_empty) begin
                        $error("queue_empty: expected %0d, got %0d", e.queue_empty,
                               m_queue_empty);
                        errors++;
                    end
                    if (m_last !== e.last) begin
                        $error("last: expected %0d, got %0d", e.last, m_last); errors++;
                    end
                end
            end
            if (hold_off > 0) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Timeout watchdog.
    always @(posedge aclk) begin
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    logic [63:0] clock_ns = 64'd5_000_000;

    function automatic void add_cmd(logic [1:0] m, logic [4:0] id, logic [31:0] p,
                                    logic os, logic [63:0] now);
        cmd_queue.push_back('{m, id, p, os, now});
    endfunction

    // Random period: mostly short so ticks catch expiries, sometimes extreme.
    function automatic logic [31:0] rand_period();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return $urandom();
            2: return 32'hFFFF_FFFF;
            default: return $urandom_range(40);
        endcase
    endfunction

    task automatic wait_drained();
        while (cmd_queue.size() > 0 || s_valid || expected_beats.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        int n;
        int m;
        foreach (tm_armed[i]) tm_armed[i] = 1'b0;
        arm_count = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty tick, extremes, re-arm, idle cancel, zero-period periodic,
        // equal deadlines (newest first), wrap of now, unused mode three
        add_cmd(MODE_TICK, 5'd0, '0, 0, 64'd0);
        add_cmd(MODE_CANCEL, 5'd3, '0, 0, 64'd0);
        add_cmd(MODE_ARM, 5'd0, 32'd0, 1'b0, 64'd100);
        add_cmd(MODE_ARM, 5'd0, 32'd7, 1'b1, 64'd100);
        add_cmd(MODE_ARM, 5'd31, 32'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        add_cmd(MODE_ARM, 5'd5, 32'd2, 1'b1, 64'd0);
        add_cmd(MODE_ARM, 5'd6, 32'd2, 1'b0, 64'd0);
        add_cmd(MODE_TICK, 5'd31, 32'hFFFF_FFFF, 1'b1, 64'd100);
        add_cmd(MODE_TICK, 5'd0, '0, 0, 64'd2_000_000);
        add_cmd(MODE_CANCEL, 5'd0, '0, 0, 64'd0);
        add_cmd(MODE_CANCEL, 5'd0, '0, 0, 64'd0);
        add_cmd(MODE_ARM, 5'd1, 32'd1, 1'b1, 64'hFFFF_FFFF_FFF0_0000);
        add_cmd(MODE_TICK, 5'd0, '0, 0, 64'h0000_0000_0010_0000);
        add_cmd(2'd3, 5'd9, 32'd9, 1'b1, 64'd9);
        add_cmd(MODE_TICK, 5'd0, '0, 0, 64'h8000_0000_0000_0000);
        add_cmd(MODE_CANCEL, 5'd31, '0, 0, 64'd0);
        add_cmd(MODE_CANCEL, 5'd6, '0, 0, 64'd0);
        add_cmd(MODE_TICK, 5'd0, '0, 0, 64'd5_000_000);

        // random phases: none, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 67 : 33) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 67 : 33) : 0;
            n = 0;
            while (n < 90) begin
                m = $urandom_range(99);
                if (m < 40) begin
                    add_cmd(MODE_ARM, 5'($urandom_range(31)), rand_period(),
                            1'($urandom_range(1)), clock_ns);
                end else if (m < 58) begin
                    add_cmd(MODE_CANCEL, 5'($urandom_range(31)), $urandom(),
                            1'($urandom_range(1)), clock_ns);
                end else if (m < 95) begin
                    if ($urandom_range(9) == 0) clock_ns = {$urandom(), $urandom()};
                    else clock_ns += 64'($urandom_range(20)) * 64'd1_000_000;
                    add_cmd(MODE_TICK, 5'($urandom_range(31)), $urandom(),
                            1'($urandom_range(1)), clock_ns);
                end else begin
                    add_cmd(2'd3, 5'($urandom_range(31)), $urandom(),
                            1'($urandom_range(1)), {$urandom(), $urandom()});
                    n--;
                end
                n++;
            end
            if (phase == 1) begin
                // long receiver hold-off while the sender keeps offering
                @(posedge aclk);
                hold_off <= 400;
            end
            // sender pause mid-stream until every expected beat is in
            repeat (200) @(posedge aclk);
            sender_pause = 1;
            while (s_valid || expected_beats.size() > 0) @(posedge aclk);
            repeat (20) @(posedge aclk);
            sender_pause = 0;
            wait_drained();
            repeat (150) @(posedge aclk);
        end
        repeat (150) @(posedge aclk);
        if (expected_beats.size() > 0) begin
            $error("%0d expected beats never arrived", expected_beats.size());
            errors++;
        end
        $display("covered arm, cancel, tick and unused mode with %0d result beats,",
                 beats_seen);
        $display("%0d expiries, across four idle and stall phases", fired_seen);
        if (errors == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- deadline_timer_queue_unit.f -----
rtl/dtq_pkg.sv
rtl/dtq_cmp.sv
rtl/deadline_timer_queue_unit.sv
tb/deadline_timer_queue_unit_tb.sv
